### rtl/vrhi_pkg.sv
package vrhi_pkg;

  // Word length limit and width of the saturating byte counter (holds limit+1)
  localparam int WORD_LIMIT = 256;
  localparam int POS_W      = $clog2(WORD_LIMIT + 2);

  // Results one input word can cause, and the index width over them
  localparam int MAX_RES  = 5;
  localparam int SLOT_W   = $clog2(MAX_RES);
  localparam int CNT_W    = $clog2(MAX_RES + 1);

  // Front-to-back queue
  localparam int Q_DEPTH  = 2;
  localparam int Q_PTR_W  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

  localparam logic [7:0] DASH_RESET = 8'd45;

  // One queue entry: the output words of one input word
  typedef struct packed {
    logic [MAX_RES-1:0][7:0] byt;
    logic [MAX_RES-1:0]      wl;
    logic [CNT_W-1:0]        n;
  } rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Outcome of deciding one pending byte
  typedef struct packed {
    logic [1:0] n;
    logic [7:0] b0;
    logic [7:0] b1;
    logic       flag;
  } dec_t;

  function automatic logic is_vowel(input logic [7:0] c);
    logic v;
    case (c) inside
      // a e o u A E O U
      8'd97, 8'd101, 8'd111, 8'd117, 8'd65, 8'd69, 8'd79, 8'd85,
      // Latin-5 vowels, plus i and I
      8'd226, 8'd253, 8'd105, 8'd238, 8'd246, 8'd252,
      8'd194, 8'd73, 8'd221, 8'd206, 8'd214, 8'd220: v = 1'b1;
      default: v = 1'b0;
    endcase
    return v;
  endfunction

  function automatic dec_t decide(input logic [7:0] b, input logic v1, input logic v2,
                                  input logic flag, input logic [7:0] dash);
    dec_t d;
    d.n    = 2'd1;
    d.b0   = b;
    d.b1   = dash;
    d.flag = 1'b0;
    if (is_vowel(b)) begin
      if (v1 || v2) d.n = 2'd2;
    end else begin
      if (flag) begin
        d.n = 2'd2;
        if (v1) begin
          d.b0 = dash;
          d.b1 = b;
        end
      end
      d.flag = ~flag;
    end
    return d;
  endfunction

endpackage

### rtl/vrhi_front.sv
module vrhi_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [7:0]           in_byte,
  input  logic                 word_end,
  input  logic [7:0]           dash,
  output logic                 rec_push,
  output vrhi_pkg::rec_t       rec
);

  logic [7:0]                  pend0, pend1;
  logic [1:0]                  pcount;
  logic                        cflag;
  logic [vrhi_pkg::POS_W-1:0]  bpos;

  logic [7:0]                  pend0_next, pend1_next;
  logic [1:0]                  pcount_next;
  logic                        cflag_next;
  logic [vrhi_pkg::POS_W-1:0]  bpos_next;

  localparam logic [vrhi_pkg::POS_W-1:0] LIM = vrhi_pkg::POS_W'(vrhi_pkg::WORD_LIMIT);
  localparam logic [vrhi_pkg::POS_W-1:0] LIM1 =
    vrhi_pkg::POS_W'(vrhi_pkg::WORD_LIMIT + 1);

  always_comb begin
    logic                        vb;
    vrhi_pkg::dec_t              d0, d1;
    logic [vrhi_pkg::CNT_W-1:0]  k;
    logic                        clr;

    vb          = vrhi_pkg::is_vowel(in_byte);
    d0          = '0;
    d1          = '0;
    k           = '0;
    clr         = 1'b0;
    rec.byt     = '0;
    rec.wl      = '0;
    pend0_next  = pend0;
    pend1_next  = pend1;
    pcount_next = pcount;
    cflag_next  = cflag;
    bpos_next   = bpos;

    if (bpos > LIM) begin
      // word closed by the limit: drop
      clr = word_end;
    end else if (bpos == LIM) begin
      if (pcount == 2'd2) begin
        d0 = vrhi_pkg::decide(pend0, vrhi_pkg::is_vowel(pend1), vb, cflag, dash);
        cflag_next = d0.flag;
        rec.byt[k[vrhi_pkg::SLOT_W-1:0]] = d0.b0;
        k = k + 1'b1;
        if (d0.n == 2'd2) begin
          rec.byt[k[vrhi_pkg::SLOT_W-1:0]] = d0.b1;
          k = k + 1'b1;
        end
        rec.byt[k[vrhi_pkg::SLOT_W-1:0]] = pend1;
        rec.wl[k[vrhi_pkg::SLOT_W-1:0]]  = 1'b1;
        k = k + 1'b1;
      end else if (pcount == 2'd1) begin
        rec.byt[k[vrhi_pkg::SLOT_W-1:0]] = pend0;
        rec.wl[k[vrhi_pkg::SLOT_W-1:0]]  = 1'b1;
        k = k + 1'b1;
      end
      if (word_end) begin
        clr = 1'b1;
      end else begin
        pcount_next = 2'd0;
        bpos_next   = LIM1;
      end
    end else if (word_end) begin
      if (pcount == 2'd2) begin
        d0 = vrhi_pkg::decide(pend0, vrhi_pkg::is_vowel(pend1), vb, cflag, dash);
        d1 = vrhi_pkg::decide(pend1, vb, 1'b0, d0.flag, dash);
      end else if (pcount == 2'd1) begin
        d0 = vrhi_pkg::decide(pend0, vb, 1'b0, cflag, dash);
      end
      if (d0.n != 2'd0) begin
        rec.byt[k[vrhi_pkg::SLOT_W-1:0]] = d0.b0;
        k = k + 1'b1;
        if (d0.n == 2'd2) begin
          rec.byt[k[vrhi_pkg::SLOT_W-1:0]] = d0.b1;
          k = k + 1'b1;
        end
      end
      if (d1.n != 2'd0) begin
        rec.byt[k[vrhi_pkg::SLOT_W-1:0]] = d1.b0;
        k = k + 1'b1;
        if (d1.n == 2'd2) begin
          rec.byt[k[vrhi_pkg::SLOT_W-1:0]] = d1.b1;
          k = k + 1'b1;
        end
      end
      rec.byt[k[vrhi_pkg::SLOT_W-1:0]] = in_byte;
      rec.wl[k[vrhi_pkg::SLOT_W-1:0]]  = 1'b1;
      k   = k + 1'b1;
      clr = 1'b1;
    end else begin
      if (pcount == 2'd2) begin
        d0 = vrhi_pkg::decide(pend0, vrhi_pkg::is_vowel(pend1), vb, cflag, dash);
        cflag_next = d0.flag;
        rec.byt[k[vrhi_pkg::SLOT_W-1:0]] = d0.b0;
        k = k + 1'b1;
        if (d0.n == 2'd2) begin
          rec.byt[k[vrhi_pkg::SLOT_W-1:0]] = d0.b1;
          k = k + 1'b1;
        end
        pend0_next = pend1;
        pend1_next = in_byte;
      end else begin
        if (pcount[0]) pend1_next = in_byte;
        else           pend0_next = in_byte;
        pcount_next = pcount + 2'd1;
      end
      bpos_next = bpos + 1'b1;
    end

    if (clr) begin
      pcount_next = 2'd0;
      cflag_next  = 1'b0;
      bpos_next   = '0;
    end

    rec.n    = k;
    rec_push = accept && (k != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pcount <= 2'd0;
      cflag  <= 1'b0;
      bpos   <= '0;
    end else if (accept) begin
      pcount <= pcount_next;
      cflag  <= cflag_next;
      bpos   <= bpos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend0 <= pend0_next;
      pend1 <= pend1_next;
    end
  end

endmodule

### rtl/vrhi_queue.sv
module vrhi_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr,
  input  vrhi_pkg::rec_t     wr_data,
  input  logic               rd,
  output vrhi_pkg::rec_t     rd_data,
  output vrhi_pkg::q_stat_t  stat
);

  vrhi_pkg::rec_t                 mem [vrhi_pkg::Q_DEPTH];
  logic [vrhi_pkg::Q_PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [vrhi_pkg::Q_CNT_W-1:0]   count;

  localparam logic [vrhi_pkg::Q_PTR_W-1:0] LAST = vrhi_pkg::Q_PTR_W'(vrhi_pkg::Q_DEPTH - 1);
  localparam logic [vrhi_pkg::Q_CNT_W-1:0] DEPTH = vrhi_pkg::Q_CNT_W'(vrhi_pkg::Q_DEPTH);

  assign stat.full  = (count == DEPTH);
  assign stat.empty = (count == '0);
  assign rd_data    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) mem[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      if (rd) rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      if (wr && !rd)      count <= count + 1'b1;
      else if (rd && !wr) count <= count - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) stat.full |-> !wr)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) stat.empty |-> !rd)
    else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= DEPTH)
    else $error("queue count out of range");

endmodule

### rtl/vrhi_back.sv
module vrhi_back (
  input  logic               clk,
  input  logic               rst,
  input  vrhi_pkg::rec_t     q_data,
  input  vrhi_pkg::q_stat_t  q_stat,
  output logic               q_rd,
  input  logic               pop,
  output logic               empty,
  output logic [7:0]         out_byte,
  output logic               run_last,
  output logic               word_last
);

  vrhi_pkg::rec_t                 cur;
  logic                           cur_valid;
  logic [vrhi_pkg::CNT_W-1:0]     idx;
  logic                           out_valid;
  logic                           advance;
  logic                           cur_last;

  assign empty    = !out_valid;
  assign advance  = !out_valid || pop;
  assign cur_last = (idx == cur.n - 1'b1);
  assign q_rd     = !q_stat.empty && (!cur_valid || (advance && cur_last));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      cur_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (advance) out_valid <= cur_valid;
      if (q_rd) begin
        cur_valid <= 1'b1;
        idx       <= '0;
      end else if (advance && cur_valid) begin
        if (cur_last) cur_valid <= 1'b0;
        else          idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && cur_valid) begin
      out_byte  <= cur.byt[idx[vrhi_pkg::SLOT_W-1:0]];
      word_last <= cur.wl[idx[vrhi_pkg::SLOT_W-1:0]];
      run_last  <= cur_last;
    end
    if (q_rd) cur <= q_data;
  end

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> (cur.n != '0) && (idx < cur.n))
    else $error("slot index past end of entry");

endmodule

### rtl/vowel_rule_hyphen_inserter.sv
// Vowel-rule hyphen inserter. Takes the bytes of a word (Latin-5 letters)
// one per push, word_end marking the last byte, and returns the word with
// dash bytes inserted: after a vowel when either of the next two bytes is a
// vowel, and around every second consonant in a row (before it when a vowel
// follows, after it otherwise). A byte is held until two lookahead bytes
// are known or the word ends; the final byte of a word comes out plain with
// word_last set, and run_last marks the last word produced by each push.
// Only the first WORD_LIMIT bytes of a word are kept; the rest are dropped
// until word_end. Rate: a push is taken every cycle while the internal
// two-entry queue has room; each push yields 0 to 5 output words and the
// output side delivers one word per cycle while pop is asserted, so
// sustained throughput is one output word per cycle while the receiver pops.
// dash_code (reset 45) is written with dash_code_we; change it only while
// the block is idle.
module vowel_rule_hyphen_inserter (
  input  logic       clk,
  input  logic       rst,
  // config
  input  logic       dash_code_we,
  input  logic [7:0] dash_code,
  // input queue side
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       word_end,
  // result queue side
  input  logic       pop,
  output logic       empty,
  output logic [7:0] out_byte,
  output logic       run_last,
  output logic       word_last
);

  logic [7:0]         dash;
  logic               accept;
  logic               rec_push;
  vrhi_pkg::rec_t     rec;
  vrhi_pkg::rec_t     q_data;
  vrhi_pkg::q_stat_t  q_stat;
  logic               q_rd;

  // dash register
  always_ff @(posedge clk) begin
    if (rst)               dash <= vrhi_pkg::DASH_RESET;
    else if (dash_code_we) dash <= dash_code;
  end

  // a word is taken whenever the queue can take its results
  assign full   = q_stat.full;
  assign accept = push && !q_stat.full;

  // front: lookahead and rule decisions, one input word per cycle while the queue is not full
  vrhi_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .in_byte  (in_byte),
    .word_end (word_end),
    .dash     (dash),
    .rec_push (rec_push),
    .rec      (rec)
  );

  // decoupling queue of result groups
  vrhi_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (rec_push),
    .wr_data (rec),
    .rd      (q_rd),
    .rd_data (q_data),
    .stat    (q_stat)
  );

  // back: serializes each group into output words
  vrhi_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_data    (q_data),
    .q_stat    (q_stat),
    .q_rd      (q_rd),
    .pop       (pop),
    .empty     (empty),
    .out_byte  (out_byte),
    .run_last  (run_last),
    .word_last (word_last)
  );

endmodule

### verif/hyphen_check.sv
module hyphen_check (
  input  logic       clk,
  input  logic       rst,
  input  logic       dash_code_we,
  input  logic [7:0] dash_code,
  input  logic       push,
  input  logic       full,
  input  logic [7:0] in_byte,
  input  logic       word_end,
  input  logic       pop,
  input  logic       empty,
  input  logic [7:0] out_byte,
  input  logic       run_last,
  input  logic       word_last,
  output int         errors,
  output int         owed
);

  localparam int PRINT_CAP = 100;

  typedef struct {
    logic [7:0] byt;
    logic       rl;
    logic       wl;
  } hyph_word_t;

  hyph_word_t  owed_bytes[$];
  logic [7:0]  dash_r;
  logic [7:0]  held0;
  logic [7:0]  held1;
  logic [1:0]  held_n;
  logic        cons_odd;
  int unsigned token_pos;
  int          err_n;
  int          added;

  function automatic logic vowel(input logic [7:0] c);
    case (c)
      "a", "e", "o", "u", "A", "E", "O", "U",
      8'd226, 8'd253, 8'd105, 8'd238, 8'd246, 8'd252,
      8'd194, 8'd73, 8'd221, 8'd206, 8'd214, 8'd220: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  task automatic report(input string what, input int want, input int got);
    err_n++;
    if (err_n <= PRINT_CAP)
      $display("%0t mismatch: %s expected %0d got %0d", $time, what, want, got);
  endtask

  task automatic put_word(input logic [7:0] b, input logic wl);
    owed_bytes.push_back('{byt: b, rl: 1'b0, wl: wl});
    added++;
  endtask

  // vowel rules for one held byte, given its two lookahead vowel flags
  task automatic judge(input logic [7:0] b, input logic v1, input logic v2);
    if (vowel(b)) begin
      cons_odd = 1'b0;
      put_word(b, 1'b0);
      if (v1 || v2) put_word(dash_r, 1'b0);
    end else begin
      if (cons_odd && v1) begin
        put_word(dash_r, 1'b0);
        put_word(b, 1'b0);
      end else if (cons_odd) begin
        put_word(b, 1'b0);
        put_word(dash_r, 1'b0);
      end else begin
        put_word(b, 1'b0);
      end
      cons_odd = ~cons_odd;
    end
  endtask

  task automatic clear_token();
    held0     = 8'd0;
    held1     = 8'd0;
    held_n    = 2'd0;
    cons_odd  = 1'b0;
    token_pos = 0;
  endtask

  task automatic hyphenate(input logic [7:0] b, input logic e);
    logic vb;
    vb    = vowel(b);
    added = 0;
    if (token_pos > vrhi_pkg::WORD_LIMIT) begin
      // past the limit: dropped, the end mark only closes the token
      if (e) clear_token();
    end else if (token_pos == vrhi_pkg::WORD_LIMIT) begin
      if (held_n == 2'd2) begin
        judge(held0, vowel(held1), vb);
        put_word(held1, 1'b1);
      end else if (held_n == 2'd1) begin
        put_word(held0, 1'b1);
      end
      if (e) begin
        clear_token();
      end else begin
        held_n    = 2'd0;
        token_pos = vrhi_pkg::WORD_LIMIT + 1;
      end
    end else if (e) begin
      if (held_n == 2'd2) begin
        judge(held0, vowel(held1), vb);
        judge(held1, vb, 1'b0);
      end else if (held_n == 2'd1) begin
        judge(held0, vb, 1'b0);
      end
      put_word(b, 1'b1);
      clear_token();
    end else begin
      if (held_n == 2'd2) begin
        judge(held0, vowel(held1), vb);
        held0 = held1;
        held1 = b;
      end else if (held_n == 2'd1) begin
        held1  = b;
        held_n = 2'd2;
      end else begin
        held0  = b;
        held_n = 2'd1;
      end
      token_pos++;
    end
    if (added > 0) owed_bytes[owed_bytes.size() - 1].rl = 1'b1;
  endtask

  always @(posedge clk) begin : watch
    hyph_word_t head;
    if (rst) begin
      dash_r = vrhi_pkg::DASH_RESET;
      clear_token();
      owed_bytes.delete();
      err_n = 0;
    end else begin
      if (dash_code_we) dash_r = dash_code;
      // outputs first: a word popped now was produced by an earlier push
      if (pop && !empty) begin
        if (owed_bytes.size() == 0) begin
          report("word with nothing owed, out_byte", -1, out_byte);
        end else begin
          head = owed_bytes.pop_front();
          if (out_byte !== head.byt) report("out_byte", head.byt, out_byte);
          if (run_last !== head.rl) report("run_last", head.rl, run_last);
          if (word_last !== head.wl) report("word_last", head.wl, word_last);
        end
      end
      if (push && !full) hyphenate(in_byte, word_end);
    end
    errors <= err_n;
    owed   <= owed_bytes.size();
  end

endmodule

### verif/tb_vowel_rule_hyphen_inserter.sv
module tb_vowel_rule_hyphen_inserter;

  // Silent cycles allowed before the run is declared hung. The longest
  // legal silence is the receiver hold-off (HOLD_CYCLES) plus settle waits.
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  // Give the block some margin to settle before touching config.
  localparam int SETTLE      = 10;
  localparam int PHASE_WORDS = 26;

  logic       clk          = 1'b0;
  logic       rst          = 1'b1;
  logic       dash_code_we = 1'b0;
  logic [7:0] dash_code    = vrhi_pkg::DASH_RESET;
  logic       push         = 1'b0;
  logic [7:0] in_byte      = 8'd0;
  logic       word_end     = 1'b0;
  logic       pop          = 1'b0;
  logic       full;
  logic       empty;
  logic [7:0] out_byte;
  logic       run_last;
  logic       word_last;

  int errors;
  int owed;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_reqs      = 0;  // bumped by stimulus
  int holds_done     = 0;  // bumped by the receiver
  int quiet          = 0;

  vowel_rule_hyphen_inserter u_top (
    .clk          (clk),
    .rst          (rst),
    .dash_code_we (dash_code_we),
    .dash_code    (dash_code),
    .push         (push),
    .full         (full),
    .in_byte      (in_byte),
    .word_end     (word_end),
    .pop          (pop),
    .empty        (empty),
    .out_byte     (out_byte),
    .run_last     (run_last),
    .word_last    (word_last)
  );

  hyphen_check u_check (
    .clk          (clk),
    .rst          (rst),
    .dash_code_we (dash_code_we),
    .dash_code    (dash_code),
    .push         (push),
    .full         (full),
    .in_byte      (in_byte),
    .word_end     (word_end),
    .pop          (pop),
    .empty        (empty),
    .out_byte     (out_byte),
    .run_last     (run_last),
    .word_last    (word_last),
    .errors       (errors),
    .owed         (owed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: random stalls, or a long hold-off on request so the block's
  // internal queue fills and full backs up onto the sender.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_reqs != holds_done) begin
      pop <= 1'b0;
      repeat (HOLD_CYCLES) @(posedge clk);
      holds_done = holds_done + 1;
    end else begin
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: any accepted word on either side restarts the count.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // One input word. Push stays high from one accepted word to the next
  // unless an idle cycle is drawn, so push gets one assignment per edge.
  task automatic offer(input logic [7:0] b, input logic e);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push     <= 1'b1;
    in_byte  <= b;
    word_end <= e;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // Mostly letters, about half vowels; now and then any byte at all.
  function automatic logic [7:0] pick_letter();
    logic [7:0] b;
    logic       want_v;
    int         r;
    r = $urandom_range(99);
    if (r < 10) return 8'($urandom_range(255));
    want_v = (r < 55);
    do begin
      case ($urandom_range(2))
        0:       b = 8'($urandom_range(65, 90));
        1:       b = 8'($urandom_range(97, 122));
        default: b = 8'($urandom_range(192, 255));
      endcase
    end while (vrhi_pkg::is_vowel(b) != want_v);
    return b;
  endfunction

  task automatic send_token(input int len);
    for (int i = 0; i < len; i++) offer(pick_letter(), i == len - 1);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) offer(s[i], i == s.len() - 1);
  endtask

  // Stop sending, wait until every owed word has come out, then let the
  // block settle: the last push may have been one that produces nothing.
  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (owed != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_dash(input logic [7:0] v);
    dash_code_we <= 1'b1;
    dash_code    <= v;
    @(posedge clk);
    dash_code_we <= 1'b0;
  endtask

  initial begin
    int sent;
    int len;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed tokens, reset dash (45), no idling.
    offer(8'd0, 1'b1);          // zero byte alone, still a consonant
    offer(8'd255, 1'b0);        // byte extremes
    offer(8'd0, 1'b1);
    send_text("ankara");        // vowel-vowel lookahead, cluster before vowel
    send_text("arkta");         // second consonant with no vowel after
    send_text("Ie");            // two-byte token, short lookahead
    offer(8'd220, 1'b0);        // Latin-5 vowels around a consonant
    offer(8'd231, 1'b0);
    offer(8'd253, 1'b1);
    drain();

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  set_dash(8'd0);   end
        1: begin send_idle_pct = 61; recv_stall_pct = 0;  set_dash(8'd255); end
        2: begin send_idle_pct = 0;  recv_stall_pct = 61;
                 set_dash(8'($urandom_range(255))); end
        3: begin send_idle_pct = 11; recv_stall_pct = 11;
                 set_dash(8'($urandom_range(1, 254))); end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          set_dash(vrhi_pkg::DASH_RESET);
          hold_reqs = hold_reqs + 1;  // receiver holds off while we keep pushing
        end
      endcase

      // Word limit: one token that runs past it and ends on a dropped byte.
      if (p == 0) send_token(vrhi_pkg::WORD_LIMIT + 2);

      sent = 0;
      while (sent < PHASE_WORDS) begin
        len = ($urandom_range(19) == 0) ? $urandom_range(11, 30) : $urandom_range(1, 9);
        send_token(len);
        sent += len;
      end
      drain();
    end

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
